/* src/rational_arith_unit_core_macros.svh */
// Assertion helpers shared by the core and GCD modules.
`ifndef RATIONAL_ARITH_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITH_UNIT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/rau_pkg.sv */
package rau_pkg;
    localparam int MagW = 32;
    localparam int NumW = 33;
    localparam int DenW = 32;
    localparam int InW  = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MULT, ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
    } state_t;
endpackage

/* src/rational_arith_unit_core.sv */
// Sequence: multiply in three steps, combine, then for a zero numerator or zero
//   denominator straight to the output register; otherwise the GCD handshake
//   and two divides (numerator, then denominator) before the output register.
// Throughput: one item at a time; the next item is taken only in idle, which
//   follows the load of the result into the output register; that load waits
//   for the output register to drain.
// Reset: synchronous, active low; clears sequencer and valid flags only.
module rational_arith_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], first_num[17:2], first_den[33:18], second_num[49:34],
    // second_den[65:50], zero pad to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_num[32:0], result_den[64:33], zero pad to 72
    output logic [71:0] m_tdata,
    // zero_den_error[0]
    output logic        m_tuser
);
    rau_pkg::state_t state_reg, state_next;
    rau_pkg::op_t    op_reg, op_next;
    logic signed [rau_pkg::InW-1:0] n1_reg, d1_reg, n2_reg, d2_reg;
    logic [1:0] step_reg, step_next;
    logic signed [31:0] p0_reg, p1_reg, p2_reg, prod;
    logic signed [rau_pkg::InW-1:0] mul_a, mul_b;

    logic signed [rau_pkg::NumW-1:0] raw_num;
    logic [rau_pkg::MagW-1:0] magn_reg, magn_next, magd_reg, magd_next;
    logic [rau_pkg::MagW-1:0] g_reg, g_next, qn_reg, qn_next;
    logic neg_reg, neg_next;

    logic signed [rau_pkg::NumW-1:0] res_num_reg, res_num_next;
    logic signed [rau_pkg::DenW-1:0] res_den_reg, res_den_next;
    logic res_err_reg, res_err_next;

    logic [rau_pkg::NumW-1:0] out_num_reg;
    logic [rau_pkg::DenW-1:0] out_den_reg;
    logic out_err_reg, out_valid_reg, out_load;

    // start/done pairs toward the iterative units
    logic gcd_start, gcd_done, div_start, div_done;
    logic [rau_pkg::MagW-1:0] gcd_val, div_q, div_dvd, div_dsr;

    logic s_acc;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == rau_pkg::ST_IDLE);

    // shared multiplier: one product per cycle over three steps
    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = n1_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? n2_reg : d2_reg;
            end
            2'd1: begin
                mul_a = n2_reg;
                mul_b = d1_reg;
            end
            default: begin
                mul_a = d1_reg;
                mul_b = (op_reg == rau_pkg::OP_DIV) ? n2_reg : d2_reg;
            end
        endcase
    end
    assign prod = 32'(mul_a) * 32'(mul_b);

    always_comb begin
        case (op_reg)
            rau_pkg::OP_ADD: raw_num = 33'(p0_reg) + 33'(p1_reg);
            rau_pkg::OP_SUB: raw_num = 33'(p0_reg) - 33'(p1_reg);
            default:         raw_num = 33'(p0_reg);
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        magn_next    = magn_reg;
        magd_next    = magd_reg;
        g_next       = g_reg;
        qn_next      = qn_reg;
        neg_next     = neg_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_err_next = res_err_reg;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dvd      = magn_reg;
        div_dsr      = gcd_val;
        out_load     = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_acc) begin
                    op_next    = rau_pkg::op_t'(s_tdata[1:0]);
                    step_next  = 2'd0;
                    state_next = rau_pkg::ST_MULT;
                end
            end
            rau_pkg::ST_MULT: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2) state_next = rau_pkg::ST_COMB;
            end
            rau_pkg::ST_COMB: begin
                neg_next  = raw_num[rau_pkg::NumW-1] ^ p2_reg[31];
                magn_next = raw_num[rau_pkg::NumW-1] ? 32'(-raw_num)
                                                     : raw_num[rau_pkg::MagW-1:0];
                magd_next = p2_reg[31] ? 32'(-p2_reg) : 32'(p2_reg);
                if (p2_reg == '0) begin
                    // zero denominator: raw numerator, flagged
                    res_num_next = raw_num;
                    res_den_next = '0;
                    res_err_next = 1'b1;
                    state_next   = rau_pkg::ST_OUT;
                end else if (raw_num == '0) begin
                    res_num_next = 33'sd0;
                    res_den_next = 32'sd1;
                    res_err_next = 1'b0;
                    state_next   = rau_pkg::ST_OUT;
                end else begin
                    state_next = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD: begin
                // kick off on entry: magnitudes were latched last cycle
                gcd_start = (step_reg == 2'd3);
                step_next = 2'd0;
                if (gcd_done) begin
                    g_next     = gcd_val;
                    div_start  = 1'b1;
                    state_next = rau_pkg::ST_DIVN;
                end
            end
            rau_pkg::ST_DIVN: begin
                div_dsr = g_reg;
                div_dvd = magd_reg;
                if (div_done) begin
                    qn_next    = div_q;
                    div_start  = 1'b1;
                    state_next = rau_pkg::ST_DIVD;
                end
            end
            rau_pkg::ST_DIVD: begin
                div_dsr = g_reg;
                if (div_done) begin
                    res_num_next = neg_reg ? -33'(qn_reg) : 33'(qn_reg);
                    res_den_next = div_q;
                    res_err_next = 1'b0;
                    state_next   = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end else begin
            state_reg <= state_next;
            // step 3 in COMB marks the first GCD cycle
            step_reg  <= (state_reg == rau_pkg::ST_COMB) ? 2'd3 : step_next;
            if (out_load)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
        op_reg      <= op_next;
        magn_reg    <= magn_next;
        magd_reg    <= magd_next;
        g_reg       <= g_next;
        qn_reg      <= qn_next;
        neg_reg     <= neg_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_err_reg <= res_err_next;
        if (s_acc) begin
            n1_reg <= s_tdata[17:2];
            d1_reg <= s_tdata[33:18];
            n2_reg <= s_tdata[49:34];
            d2_reg <= s_tdata[65:50];
        end
        if (state_reg == rau_pkg::ST_MULT) begin
            case (step_reg)
                2'd0:    p0_reg <= prod;
                2'd1:    p1_reg <= prod;
                default: p2_reg <= prod;
            endcase
        end
        if (out_load) begin
            out_num_reg <= res_num_reg;
            out_den_reg <= res_den_reg;
            out_err_reg <= res_err_reg;
        end
    end

    rau_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a_in    (magn_reg),
        .b_in    (magd_reg),
        .done    (gcd_done),
        .gcd     (gcd_val)
    );

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_den_reg, out_num_reg};
    assign m_tuser  = out_err_reg;

    `include "rational_arith_unit_core_macros.svh"

    `RAU_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_acc, !s_tready)
    `RAU_ASSERT_IMP(a_err_den_zero, aclk, aresetn, m_tvalid && m_tuser, out_den_reg == '0)
    `RAU_ASSERT_IMP(a_den_positive, aclk, aresetn, m_tvalid && !m_tuser,
                    !out_den_reg[rau_pkg::DenW-1] && out_den_reg != '0)
endmodule

/* src/rau_gcd.sv */
// Binary GCD: one compare/subtract/shift step per cycle. Both operands nonzero.
`include "rational_arith_unit_core_macros.svh"

module rau_gcd (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rau_pkg::MagW-1:0] a_in,
    input  logic [rau_pkg::MagW-1:0] b_in,
    output logic                     done,
    output logic [rau_pkg::MagW-1:0] gcd
);
    logic [rau_pkg::MagW-1:0] a_reg, a_next, b_reg, b_next;
    logic [4:0]               k_reg, k_next;
    logic                     busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next = a_in;
            b_next = b_in;
            k_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (a_reg == b_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 5'd1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg > b_reg) begin
                a_next = (a_reg - b_reg) >> 1;
            end else begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign done = done_reg;
    assign gcd  = a_reg << k_reg;

    `RAU_ASSERT_IMP(a_gcd_nonzero, aclk, aresetn, done_reg, a_reg != '0)
endmodule

/* src/rau_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rau_pkg::MagW-1:0] dividend,
    input  logic [rau_pkg::MagW-1:0] divisor,
    output logic                     done,
    output logic [rau_pkg::MagW-1:0] quotient
);
    localparam int CntW = $clog2(rau_pkg::MagW);

    logic [rau_pkg::MagW-1:0] rem_reg, rem_next, quo_reg, quo_next, dsr_reg, dsr_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic                     busy_reg, busy_next, done_reg, done_next;
    logic [rau_pkg::MagW:0]   trial, diff;

    always_comb begin
        trial = {rem_reg, quo_reg[rau_pkg::MagW-1]};
        diff  = trial - {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[rau_pkg::MagW] ? trial[rau_pkg::MagW-1:0]
                                           : diff[rau_pkg::MagW-1:0];
            quo_next = {quo_reg[rau_pkg::MagW-2:0], ~diff[rau_pkg::MagW]};
            cnt_next = cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(rau_pkg::MagW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
